### hdl/flpte_pkg.sv
// Shared types, codes and constants for the four-level page table engine.
`default_nettype none

package flpte_pkg;

    localparam int DEF_TABLE_PAGES = 64;
    localparam int ENTRY_W         = 64;
    localparam int IDX_W           = 9;
    localparam int FRAME_W         = 40;   // physical address bits 51:12
    localparam int VA_W            = 48;
    localparam int PA_W            = 52;
    localparam int FLAGS_W         = 12;
    localparam int OFF_W           = 12;

    localparam int SHIFT_L4 = 39;
    localparam int SHIFT_L3 = 30;
    localparam int SHIFT_L2 = 21;
    localparam int SHIFT_L1 = 12;

    localparam logic [1:0] LVL_LEAF = 2'd3;

    typedef enum logic [1:0] {
        OP_MAP       = 2'd0,
        OP_UNMAP     = 2'd1,
        OP_TRANSLATE = 2'd2,
        OP_NONE      = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_MISSING = 2'd1,
        ST_FULL    = 2'd2,
        ST_UNUSED  = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_RD,
        S_EVAL,
        S_ACT,
        S_ZERO,
        S_ALLOC,
        S_LEAF_WR,
        S_OUT
    } t_state;

    // 9-bit table index of a virtual address at walk level 0 (PML4) .. 3 (leaf)
    function automatic logic [IDX_W-1:0] va_index(input logic [VA_W-1:0] va,
                                                  input logic [1:0] lvl);
        logic [IDX_W-1:0] r;
        case (lvl)
            2'd0:    r = va[SHIFT_L4 +: IDX_W];
            2'd1:    r = va[SHIFT_L3 +: IDX_W];
            2'd2:    r = va[SHIFT_L2 +: IDX_W];
            default: r = va[SHIFT_L1 +: IDX_W];
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

### hdl/flpte_ram.sv
// Single-port table store: one write or one registered read per cycle.
`default_nettype none

module flpte_ram
    import flpte_pkg::*;
#(
    parameter int DEPTH = DEF_TABLE_PAGES * (1 << IDX_W),
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic               i_clk,
    input  wire logic               i_we,
    input  wire logic               i_re,
    input  wire logic [AW-1:0]      i_addr,
    input  wire logic [ENTRY_W-1:0] i_wdata,
    output logic      [ENTRY_W-1:0] o_rdata
);

    logic [ENTRY_W-1:0] r_mem [DEPTH];
    logic [ENTRY_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### hdl/four_level_page_table_engine.sv
// Top level of the four-level page table engine: sequencer, shared adder, store.
`default_nettype none

// Four-level x86-64 style page table engine, 4 KiB pages. The table lives in
// an internal store of TABLE_PAGES pages of 512 64-bit entries; page 0 is the
// root. Each input transfer is one operation: map, unmap or translate. After
// reset the store is swept to zero, one entry a cycle; s_axis_tready stays
// low meanwhile (configuration writes still go through). Afterwards one item
// is handled at a time: each walk level is a registered store read, then a
// check. A missing level, a full store or op 3 ends the walk early. A newly
// allocated page that was already written (only possible after a
// table_base_pa change makes a link name a page past the allocated ones) has
// its 512 entries zeroed first. The pace is set by the single store port and
// by one 40-bit adder that both decodes entry addresses and builds new table
// links. The result moves into an output register that holds it until
// m_axis_tready takes it; the next item is taken the cycle after, and only
// waits if the previous result is still unclaimed when the new one is ready.
// Status 1 means an intermediate level is missing or names no page of the
// store, status 2 that map needs more free table pages than remain; in either
// case nothing is changed. Write table_base_pa only while no item is in flight.

module four_level_page_table_engine
    import flpte_pkg::*;
#(
    parameter int TABLE_PAGES = DEF_TABLE_PAGES
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    // configuration: table_base_pa
    input  wire logic          i_cfg_wr_en,
    input  wire logic [51:0]   i_cfg_wr_data,
    // input stream
    input  wire logic          s_axis_tvalid,
    output logic               s_axis_tready,
    // [47:0] virt_addr, [99:48] phys_addr, [111:100] leaf_flags,
    // [112] no_execute, [119:113] zero
    input  wire logic [119:0]  s_axis_tdata,
    // [1:0] op
    input  wire logic [1:0]    s_axis_tuser,
    // output stream
    output logic               m_axis_tvalid,
    input  wire logic          m_axis_tready,
    // [51:0] result_pa, [55:52] zero
    output logic [55:0]        m_axis_tdata,
    // [1:0] status
    output logic [1:0]         m_axis_tuser
);

    localparam int PW    = (TABLE_PAGES > 1) ? $clog2(TABLE_PAGES) : 1;
    localparam int NFW   = $clog2(TABLE_PAGES + 1);
    localparam int DEPTH = TABLE_PAGES * (1 << IDX_W);
    localparam int AW    = $clog2(DEPTH);
    localparam logic [FRAME_W-1:0] PAGES_F = FRAME_W'(TABLE_PAGES);
    localparam logic [NFW:0]       PAGES_N = (NFW + 1)'(TABLE_PAGES);
    localparam logic [AW-1:0]      LAST_A  = AW'(DEPTH - 1);

    // ---------------- registers ----------------
    t_state               r_state, n_state;
    logic [FRAME_W-1:0]   r_base;                  // table_base_pa[51:12]
    logic [AW-1:0]        r_clr, n_clr;            // sweep address / page zeroing count
    logic [NFW-1:0]       r_next_free, n_next_free;
    logic [NFW-1:0]       r_clean_from, n_clean_from; // pages from here unwritten since sweep
    logic [PW-1:0]        r_cur, n_cur;            // current table page
    logic [1:0]           r_level, n_level;
    t_op                  r_op, n_op;
    logic [VA_W-1:0]      r_va, n_va;
    logic [FRAME_W-1:0]   r_pa_frame, n_pa_frame;
    logic [FLAGS_W-1:0]   r_flags, n_flags;
    logic                 r_nx, n_nx;
    logic [PA_W-1:0]      r_res_pa, n_res_pa;
    t_status              r_status, n_status;
    // output register
    logic                 r_out_valid, n_out_valid;
    logic [PA_W-1:0]      r_out_pa, n_out_pa;
    t_status              r_out_st, n_out_st;

    // ---------------- store ----------------
    logic                 mem_we, mem_re;
    logic [AW-1:0]        mem_addr;
    logic [ENTRY_W-1:0]   mem_wdata, mem_rdata;

    flpte_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_re    (mem_re),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    // ---------------- shared 40-bit adder ----------------
    // EVAL: entry frame minus base frame gives the page number.
    // ALLOC: base frame plus the new page number gives the link frame.
    logic [FRAME_W-1:0]   add_a, add_b, add_sum;
    logic                 add_sub;

    assign add_sum = add_a + (add_sub ? ~add_b : add_b) + FRAME_W'(add_sub);

    // entry slot in the current page at the current level
    logic [AW-1:0]        walk_addr;
    assign walk_addr = AW'({r_cur, va_index(r_va, r_level)});

    logic [NFW:0]         need_end;                // next_free + missing levels
    assign need_end = {1'b0, r_next_free} + (NFW + 1)'(LVL_LEAF - r_level);

    // one past the current page, marks a write into it
    logic [NFW-1:0]       cur_end;
    assign cur_end = NFW'(r_cur) + NFW'(1);

    logic                 s_acc;
    assign s_acc = s_axis_tvalid && s_axis_tready;

    // ---------------- configuration ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= '0;
        end else if (i_cfg_wr_en) begin
            r_base <= i_cfg_wr_data[51:12];
        end
    end

    // ---------------- state registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr        <= '0;
            r_next_free  <= NFW'(1);
            r_clean_from <= NFW'(1);
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_clr        <= n_clr;
            r_next_free  <= n_next_free;
            r_clean_from <= n_clean_from;
            r_out_valid  <= n_out_valid;
        end
    end

    // payload / walk registers, no reset needed
    always_ff @(posedge i_clk) begin
        r_cur      <= n_cur;
        r_level    <= n_level;
        r_op       <= n_op;
        r_va       <= n_va;
        r_pa_frame <= n_pa_frame;
        r_flags    <= n_flags;
        r_nx       <= n_nx;
        r_res_pa   <= n_res_pa;
        r_status   <= n_status;
        r_out_pa   <= n_out_pa;
        r_out_st   <= n_out_st;
    end

    // ---------------- sequencer ----------------
    always_comb begin
        n_state      = r_state;
        n_clr        = r_clr;
        n_next_free  = r_next_free;
        n_clean_from = r_clean_from;
        n_cur        = r_cur;
        n_level      = r_level;
        n_op         = r_op;
        n_va         = r_va;
        n_pa_frame   = r_pa_frame;
        n_flags      = r_flags;
        n_nx         = r_nx;
        n_res_pa     = r_res_pa;
        n_status     = r_status;

        // a waiting result leaves on tready
        n_out_valid  = r_out_valid && !m_axis_tready;
        n_out_pa     = r_out_pa;
        n_out_st     = r_out_st;

        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_addr  = walk_addr;
        mem_wdata = '0;

        add_a   = mem_rdata[51:12];
        add_b   = r_base;
        add_sub = 1'b1;

        s_axis_tready = 1'b0;

        case (r_state)
            S_CLEAR: begin
                mem_we   = 1'b1;
                mem_addr = r_clr;
                n_clr    = r_clr + AW'(1);
                if (r_clr == LAST_A) begin
                    n_clr   = '0;
                    n_state = S_IDLE;
                end
            end

            S_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_acc) begin
                    n_op       = t_op'(s_axis_tuser);
                    n_va       = s_axis_tdata[47:0];
                    n_pa_frame = s_axis_tdata[99:60];
                    n_flags    = s_axis_tdata[111:100];
                    n_nx       = s_axis_tdata[112];
                    n_cur      = '0;
                    n_level    = '0;
                    n_res_pa   = '0;
                    n_status   = ST_DONE;
                    if (t_op'(s_axis_tuser) == OP_NONE) begin
                        n_state = S_OUT;
                    end else begin
                        n_state = S_RD;
                    end
                end
            end

            S_RD: begin
                mem_re  = 1'b1;
                n_state = S_EVAL;
            end

            S_EVAL: begin
                if (r_level == LVL_LEAF) begin
                    // leaf read, translate only
                    n_res_pa = {mem_rdata[51:12], r_va[OFF_W-1:0]};
                    n_state  = S_OUT;
                end else if (!mem_rdata[0]) begin
                    n_state = S_ACT;
                end else if (add_sum >= PAGES_F) begin
                    // present but outside the store
                    n_status = ST_MISSING;
                    n_state  = S_OUT;
                end else begin
                    n_cur   = add_sum[PW-1:0];
                    n_level = r_level + 2'd1;
                    n_state = (r_level == 2'd2) ? S_ACT : S_RD;
                end
            end

            S_ACT: begin
                case (r_op)
                    OP_MAP: begin
                        if (need_end > PAGES_N) begin
                            n_status = ST_FULL;
                            n_state  = S_OUT;
                        end else if (r_level == LVL_LEAF) begin
                            n_state = S_LEAF_WR;
                        end else if (r_next_free < r_clean_from) begin
                            n_state = S_ZERO;
                        end else begin
                            n_state = S_ALLOC;
                        end
                    end
                    OP_UNMAP: begin
                        if (r_level != LVL_LEAF) begin
                            n_status = ST_MISSING;
                            n_state  = S_OUT;
                        end else begin
                            n_state = S_LEAF_WR;
                        end
                    end
                    default: begin
                        if (r_level != LVL_LEAF) begin
                            n_status = ST_MISSING;
                            n_state  = S_OUT;
                        end else begin
                            n_state = S_RD;
                        end
                    end
                endcase
            end

            S_ZERO: begin
                // new page was written before allocation: clear it first
                mem_we   = 1'b1;
                mem_addr = AW'({r_next_free[PW-1:0], r_clr[IDX_W-1:0]});
                n_clr    = r_clr + AW'(1);
                if (r_clr[IDX_W-1:0] == '1) begin
                    n_clr   = '0;
                    n_state = S_ALLOC;
                end
            end

            S_ALLOC: begin
                // new page is zero: untouched since the sweep, or just cleared
                add_a       = r_base;
                add_b       = FRAME_W'(r_next_free);
                add_sub     = 1'b0;
                mem_we      = 1'b1;
                mem_wdata   = {12'd0, add_sum, 10'd0, 2'b11};
                if (cur_end > r_clean_from) begin
                    n_clean_from = cur_end;
                end
                n_cur       = r_next_free[PW-1:0];
                n_next_free = r_next_free + NFW'(1);
                n_level     = r_level + 2'd1;
                if (r_level == 2'd2) begin
                    n_state = S_LEAF_WR;
                end else if (n_next_free < n_clean_from) begin
                    n_state = S_ZERO;
                end
            end

            S_LEAF_WR: begin
                mem_we = 1'b1;
                if (r_op == OP_MAP) begin
                    mem_wdata = {r_nx, 11'd0, r_pa_frame, r_flags};
                end
                if (cur_end > r_clean_from) begin
                    n_clean_from = cur_end;
                end
                n_state = S_OUT;
            end

            S_OUT: begin
                // load the output register once it is free or emptying
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_pa    = r_res_pa;
                    n_out_st    = r_status;
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'd0, r_out_pa};
    assign m_axis_tuser  = r_out_st;

endmodule

`default_nettype wire

### tb/tb.sv
// Self-checking testbench for four_level_page_table_engine: stream driver, predictor, scoreboard.
`timescale 1ns / 1ps

module tb;
    import flpte_pkg::*;

    localparam int TBL_PAGES  = DEF_TABLE_PAGES;
    localparam int TBL_SLOTS  = TBL_PAGES * 512;
    localparam int POOL_DEPTH = 32;

    // One expected response: translated address plus status.
    typedef struct {
        bit [PA_W-1:0] pa;
        t_status       st;
    } walk_result_t;

    // Shadow page table plus the queue of responses it predicts.
    class walk_predictor;
        bit [ENTRY_W-1:0] shadow_table [TBL_SLOTS];
        int unsigned      next_page;
        bit [PA_W-1:0]    base_pa;
        walk_result_t     expected_walks [$];
        int unsigned      fails;

        function new();
            foreach (shadow_table[k]) shadow_table[k] = '0;
            next_page = 1;      // page 0 is the root
            base_pa   = '0;
            fails     = 0;
        endfunction

        function void set_base(bit [PA_W-1:0] v);
            base_pa = v;
        endfunction

        // Frame number (PA bits 51:12) of table page p; wraps at 2^52.
        function bit [FRAME_W-1:0] page_frame(int unsigned p);
            return base_pa[PA_W-1:OFF_W] + FRAME_W'(p);
        endfunction

        // Walk the shadow table for one accepted request and queue the response.
        function void note_request(t_op op, bit [VA_W-1:0] va, bit [PA_W-1:0] pa,
                                   bit [FLAGS_W-1:0] flags, bit nx);
            bit [IDX_W-1:0]   idx [4];
            bit [ENTRY_W-1:0] ent;
            bit [FRAME_W-1:0] page_dist;
            int unsigned      cur, lvl, np, l, k;
            bit               unreachable;
            walk_result_t     r;
            r.pa = '0;
            r.st = ST_DONE;
            cur = 0;
            lvl = 0;
            unreachable = 0;
            for (l = 0; l < 4; l++) idx[l] = va[SHIFT_L4 - 9*l +: IDX_W];
            if (op != OP_NONE) begin
                // intermediate levels, stop at the first non-present entry
                while (lvl < 3) begin
                    ent = shadow_table[cur*512 + idx[lvl]];
                    if (!ent[0]) break;
                    page_dist = ent[PA_W-1:OFF_W] - base_pa[PA_W-1:OFF_W];
                    if (page_dist >= TBL_PAGES) begin
                        unreachable = 1;
                        break;
                    end
                    cur = 32'(page_dist);
                    lvl++;
                end
                if (unreachable) begin
                    r.st = ST_MISSING;
                end else if (op == OP_MAP) begin
                    if (next_page + (3 - lvl) > TBL_PAGES) begin
                        r.st = ST_FULL;
                    end else begin
                        while (lvl < 3) begin
                            np = next_page;
                            next_page++;
                            for (k = 0; k < 512; k++) shadow_table[np*512 + k] = '0;
                            shadow_table[cur*512 + idx[lvl]] =
                                {12'h000, page_frame(np), 12'h003};
                            cur = np;
                            lvl++;
                        end
                        shadow_table[cur*512 + idx[3]] = {nx, 11'h000, pa[PA_W-1:OFF_W], flags};
                    end
                end else if (lvl < 3) begin
                    r.st = ST_MISSING;
                end else if (op == OP_UNMAP) begin
                    shadow_table[cur*512 + idx[3]] = '0;
                end else begin
                    ent  = shadow_table[cur*512 + idx[3]];
                    r.pa = {ent[PA_W-1:OFF_W], va[OFF_W-1:0]};
                end
            end
            expected_walks.push_back(r);
        endfunction

        function void check_response(bit [PA_W-1:0] pa, bit [1:0] st);
            walk_result_t want;
            if (expected_walks.size() == 0) begin
                $error("unexpected response: result_pa %h status %0d", pa, st);
                fails++;
                return;
            end
            want = expected_walks.pop_front();
            if (pa !== want.pa) begin
                $error("result_pa: expected %h, got %h", want.pa, pa);
                fails++;
            end
            if (st !== want.st) begin
                $error("status: expected %0d, got %0d", want.st, st);
                fails++;
            end
        endfunction
    endclass

    // ---------------------------------------------------------------
    // DUT signals; every input has a known value from time zero
    // ---------------------------------------------------------------
    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          i_cfg_wr_en = 1'b0;
    logic [51:0]   i_cfg_wr_data = '0;
    logic          s_tvalid = 1'b0;
    logic [119:0]  s_tdata = '0;
    logic [1:0]    s_tuser = '0;
    logic          m_tready = 1'b0;
    wire           s_axis_tready;
    wire           m_axis_tvalid;
    wire  [55:0]   m_axis_tdata;
    wire  [1:0]    m_axis_tuser;

    walk_predictor sb;
    bit            steady = 1'b0;       // no random idling on either side while set
    bit [35:0]     known_pages [$];     // va[47:12] of recently mapped pages

    four_level_page_table_engine #(
        .TABLE_PAGES (TBL_PAGES)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_tdata),
        .s_axis_tuser  (s_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Response side: check each transfer, then pick the next tready.
    // All DUT outputs are read right after the edge, before any NBA lands.
    always @(posedge i_clk) begin
        if (m_axis_tvalid && m_tready)
            sb.check_response(m_axis_tdata[PA_W-1:0], m_axis_tuser);
        m_tready <= steady || ($urandom_range(99) >= 21);
    end

    // Hard stop in case the DUT hangs; slowest legal run is well under this.
    initial begin
        #20_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // ---------------------------------------------------------------
    // Request side
    // ---------------------------------------------------------------

    // Present one request and hold it until the transfer happens.
    // tvalid is only dropped in the idle loop, so a back-to-back request
    // never sees a low and a high NBA in the same step.
    task automatic send_op(t_op op, bit [VA_W-1:0] va, bit [PA_W-1:0] pa,
                           bit [FLAGS_W-1:0] flags, bit nx);
        while (!steady && $urandom_range(99) < 21) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'h00, nx, flags, pa, va};
        s_tuser  <= op;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_request(op, va, pa, flags, nx);
    endtask

    // Stop sending and let every outstanding response drain.
    task automatic drain_walks();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.expected_walks.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
    endtask

    task automatic write_base(bit [PA_W-1:0] v);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        sb.set_base(v);
    endtask

    // Random request. Most hit pages already mapped (or their neighbors) so
    // walks reach the leaf; fresh_pct of them use a fully random address,
    // which is what allocates new tables and eventually fills the store.
    task automatic send_random(int unsigned fresh_pct);
        bit [63:0]   r;
        bit [63:0]   d;
        bit [47:0]   va;
        bit [35:0]   pg;
        t_op         op;
        int unsigned pick, lvl;
        pick = $urandom_range(99);
        op = (pick < 42) ? OP_MAP : (pick < 76) ? OP_TRANSLATE :
             (pick < 94) ? OP_UNMAP : OP_NONE;
        r  = {$urandom(), $urandom()};
        d  = {$urandom(), $urandom()};
        va = r[47:0];
        if (known_pages.size() != 0 && $urandom_range(99) >= fresh_pct) begin
            pg   = known_pages[$urandom_range(known_pages.size() - 1)];
            pick = $urandom_range(99);
            if (pick < 10) begin
                // neighbor at an upper level: PML4, PDPT or PD index changed
                lvl = $urandom_range(2);
                pg[35 - 9*lvl -: 9] = r[60:52];
            end else if (pick < 40) begin
                pg[8:0] = r[60:52];     // same leaf table, other slot
            end
            va[47:12] = pg;
        end
        if (op == OP_MAP) begin
            if (known_pages.size() < POOL_DEPTH)
                known_pages.push_back(va[47:12]);
            else
                known_pages[$urandom_range(POOL_DEPTH - 1)] = va[47:12];
        end
        send_op(op, va, d[51:0], d[63:52], 1'($urandom_range(1)));
    endtask

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial begin
        int n;
        sb = new();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // base write lands during the post-reset clear sweep
        write_base(52'h0);

        // directed: empty table, op 3, extremes, overwrite, partial walks
        send_op(OP_TRANSLATE, 48'h0000_0000_0123, '0, '0, 1'b0);    // root empty
        send_op(OP_UNMAP,     48'h0000_0000_0000, '0, '0, 1'b0);
        send_op(OP_NONE,      '1, '1, '1, 1'b1);                    // ignored op
        send_op(OP_MAP,       48'h0000_0000_0000, '0, '0, 1'b0);    // three allocs
        send_op(OP_TRANSLATE, 48'h0000_0000_0fff, '0, '0, 1'b0);
        send_op(OP_MAP,       '1, '1, '1, 1'b1);                    // all ones
        send_op(OP_TRANSLATE, '1, '0, '0, 1'b0);
        send_op(OP_MAP,       48'h0000_0000_1000, 52'h1_2345_6789_abcd, 12'h007, 1'b0);
        send_op(OP_TRANSLATE, 48'h0000_0000_1abc, '0, '0, 1'b0);
        send_op(OP_UNMAP,     48'h0000_0000_1fff, '0, '0, 1'b0);
        send_op(OP_TRANSLATE, 48'h0000_0000_1234, '0, '0, 1'b0);    // cleared leaf
        send_op(OP_TRANSLATE, 48'h0000_4000_0000, '0, '0, 1'b0);    // PDPT missing
        send_op(OP_UNMAP,     48'h0000_4000_0000, '0, '0, 1'b0);
        send_op(OP_TRANSLATE, 48'h0000_0020_0000, '0, '0, 1'b0);    // PD missing
        send_op(OP_MAP,       48'h0000_0020_0000, 52'h0_0000_0abc_d000, 12'h003, 1'b1);
        send_op(OP_TRANSLATE, 48'h0000_0020_0555, '0, '0, 1'b0);
        send_op(OP_MAP,       48'h0000_0000_0000, 52'hf_0000_0000_0fff, 12'h800, 1'b0);
        send_op(OP_TRANSLATE, 48'h0000_0000_0001, '0, '0, 1'b0);    // overwritten leaf
        send_op(OP_MAP,       48'h8000_0000_0000, 52'h8_0000_0000_1000, 12'h005, 1'b1);
        send_op(OP_TRANSLATE, 48'h8000_0000_0fff, '0, '0, 1'b0);
        send_op(OP_UNMAP,     48'h0000_0000_7000, '0, '0, 1'b0);    // never-mapped slot
        send_op(OP_NONE,      '0, '0, '0, 1'b0);
        known_pages.push_back(36'h0_0000_0000);
        known_pages.push_back(36'h0_0000_0200);
        known_pages.push_back(36'h8_0000_0000);

        // phase A: base 0, with a stretch of back-to-back traffic
        for (n = 0; n < 600; n++) begin
            steady <= (n >= 150 && n < 400);
            send_random(4);
        end
        steady <= 1'b0;
        drain_walks();

        // phase B: base at the top of the 52-bit space (low bits ignored),
        // so existing links decode to shifted pages or fall outside
        write_base('1);
        for (n = 0; n < 250; n++) send_random(6);
        drain_walks();

        // phase C: small unaligned base
        write_base(52'h0_0000_0000_35a5);
        for (n = 0; n < 200; n++) send_random(6);
        drain_walks();

        // phase D: arbitrary base, old links mostly unreachable
        write_base(PA_W'({$urandom(), $urandom()}));
        for (n = 0; n < 200; n++) send_random(10);
        drain_walks();

        // phase E: back to base 0, the original tables reappear
        write_base(52'h0);
        for (n = 0; n < 380; n++) send_random(8);
        drain_walks();
        repeat (32) @(posedge i_clk);

        if (sb.fails == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

### filelist.f
hdl/flpte_pkg.sv
hdl/flpte_ram.sv
hdl/four_level_page_table_engine.sv
tb/tb.sv
